// ----- rtl/core/drf_pkg.sv -----
// Shared types and constants of the delta regression feature block.
// No dependencies; the controller, datapath, top level and bench import this package.
package drf_pkg;

  // Widths fixed by the item fields and by the supported parameter range
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned DELTA_W      = 33;
  localparam int unsigned FRAME_W      = 16;
  localparam int unsigned COLUMN_W     = 6;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned CFG_HW_W     = 4;
  localparam int unsigned CFG_COLS_W   = 7;
  localparam int unsigned HW_LIMIT     = 16;  // largest supported half width
  localparam int unsigned HW_W         = 5;   // holds 0..HW_LIMIT
  localparam int unsigned ACC_W        = 42;  // signed weighted sum, worst case
  localparam int unsigned DEN_W        = 12;  // holds the largest divisor
  localparam int unsigned DIV_CNT_W    = 6;   // counts ACC_W divider steps

  // Register reset values
  localparam logic [CFG_HW_W-1:0]   HALF_WIDTH_RESET = 4'd2;
  localparam logic [CFG_COLS_W-1:0] COLUMNS_RESET    = 7'd13;

  // Register indexes
  typedef enum logic {
    REG_HALF_WIDTH = 1'b0,
    REG_COLUMNS    = 1'b1
  } cfg_reg_e;

  // Divisor table: twice the sum of squares, W*(W+1)*(2W+1)/3
  typedef logic [DEN_W-1:0] denom_tab_t [0:HW_LIMIT];

  function automatic denom_tab_t build_denom_tab();
    denom_tab_t tab;
    for (int i = 0; i <= HW_LIMIT; i++) begin
      tab[i] = DEN_W'((i * (i + 1) * (2 * i + 1)) / 3);
    end
    return tab;
  endfunction

  localparam denom_tab_t DENOM_TAB = build_denom_tab();

  // Channel payloads
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       final_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_value;
    logic [FRAME_W-1:0]        frame_number;
    logic [COLUMN_W-1:0]       column_number;
    logic                      run_end;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_START,
    ST_READ,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_EMIT
  } drf_state_e;

  // Controller to datapath
  typedef struct packed {
    logic            take;       // latch the input item, advance counters
    logic            write;      // store the sample in the frame ring
    logic            acc_clr;    // start a new weighted sum
    logic            rd_en;      // fetch one tap
    logic            rd_behind;  // tap lies before the target frame
    logic [HW_W-1:0] tap;        // tap distance l
    logic [HW_W-1:0] lag;        // target frame lies lag frames back
    logic            div_load;
    logic            div_step;
    logic            emit;
    logic            run_end;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [HW_W-1:0] half_width;
    logic [HW_W-1:0] lag_first;  // lag of the oldest result of this item
    logic            emit_any;
    logic            final_item;
    logic            out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/drf_stream_if.sv -----
// Valid/ready channel carrying one item of a payload type.
// Payload types come from drf_pkg.
interface drf_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/drf_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module drf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/drf_ctrl.sv -----
// Sequencer: walks results, taps and divider steps for one item at a time.
// Depends on drf_pkg for state, command and status types.
module drf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drf_pkg::dp_status_t status_i,
  output drf_pkg::dp_cmd_t    cmd_o
);
  import drf_pkg::*;

  drf_state_e           state_q, state_d;
  logic [HW_W-1:0]      lag_q, lag_d;
  logic [HW_W-1:0]      tap_q, tap_d;
  logic                 side_q, side_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // State and loop registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lag_q   <= '0;
      tap_q   <= '0;
      side_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lag_q   <= lag_d;
      tap_q   <= tap_d;
      side_q  <= side_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    lag_d      = lag_q;
    tap_d      = tap_q;
    side_d     = side_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.tap  = tap_q;
    cmd_o.lag  = lag_q;
    cmd_o.rd_behind = side_q;
    cmd_o.run_end   = !status_i.final_item || (lag_q == '0);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        lag_d       = status_i.lag_first;
        state_d     = status_i.emit_any ? ST_START : ST_IDLE;
      end
      ST_START: begin
        cmd_o.acc_clr = 1'b1;
        tap_d         = HW_W'(1);
        side_d        = 1'b0;
        state_d       = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        if (side_q) begin
          side_d = 1'b0;
          if (tap_q == status_i.half_width) begin
            state_d = ST_DRAIN;
          end else begin
            tap_d = tap_q + HW_W'(1);
          end
        end else begin
          side_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = DIV_CNT_W'(ACC_W - 1);
        state_d        = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cmd_o.run_end) begin
            state_d = ST_IDLE;
          end else begin
            lag_d   = lag_q - HW_W'(1);
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/drf_datapath.sv -----
// Datapath: configuration, frame counters, frame ring and first-frame RAMs,
// weighted accumulator, restoring divider and output register.
// Depends on drf_pkg and drf_ram.
module drf_datapath #(
  parameter int unsigned MAX_HALF_WIDTH = 8,
  parameter int unsigned MAX_COLUMNS    = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [drf_pkg::CFG_W-1:0]        cfg_data_i,
  input  drf_pkg::in_item_t                in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output drf_pkg::out_item_t               out_data_o,
  input  drf_pkg::dp_cmd_t                 cmd_i,
  output drf_pkg::dp_status_t              status_o
);
  import drf_pkg::*;

  localparam int unsigned RING   = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned SW     = $clog2(RING);
  localparam int unsigned HLW    = $clog2(RING + 1);
  localparam int unsigned RW2    = $clog2(2 * RING);
  localparam int unsigned CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CMPW   = (CW + 1 > CFG_COLS_W) ? CW + 1 : CFG_COLS_W;
  localparam int unsigned RDEPTH = RING * MAX_COLUMNS;
  localparam int unsigned AW     = $clog2(RDEPTH);
  localparam int unsigned FDEPTH = (MAX_COLUMNS > 1) ? MAX_COLUMNS : 2;
  localparam int unsigned FAW    = $clog2(FDEPTH);

  // Configuration registers
  logic [CFG_HW_W-1:0]   half_width_q;
  logic [CFG_COLS_W-1:0] columns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RESET;
      columns_q    <= COLUMNS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_HALF_WIDTH: half_width_q <= cfg_data_i[CFG_HW_W-1:0];
        REG_COLUMNS:    columns_q    <= cfg_data_i[CFG_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported range
  logic [HW_W-1:0] w_eff;
  logic [CMPW-1:0] cols_eff;

  always_comb begin
    w_eff = HW_W'(half_width_q);
    if (w_eff == '0) begin
      w_eff = HW_W'(1);
    end else if (w_eff > HW_W'(MAX_HALF_WIDTH)) begin
      w_eff = HW_W'(MAX_HALF_WIDTH);
    end
    cols_eff = CMPW'(columns_q);
    if (cols_eff == '0) begin
      cols_eff = CMPW'(1);
    end else if (cols_eff > CMPW'(MAX_COLUMNS)) begin
      cols_eff = CMPW'(MAX_COLUMNS);
    end
  end

  // Sequence position and the copy taken with each item
  logic [CW-1:0]          col_cnt_q;
  logic [FRAME_W-1:0]     frame_cnt_q;
  logic [SW-1:0]          slot_q;
  logic [HLW-1:0]         held_q;
  logic signed [SAMPLE_W-1:0] value_q;
  logic                   final_q;
  logic [CW-1:0]          col_l_q;
  logic [FRAME_W-1:0]     frame_l_q;
  logic [SW-1:0]          slot_l_q;
  logic [HLW-1:0]         held_l_q;
  logic [HW_W-1:0]        w_l_q;
  logic                   last_col;

  assign last_col = (CMPW'(col_cnt_q) + CMPW'(1)) >= cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      frame_cnt_q <= '0;
      slot_q      <= '0;
      held_q      <= '0;
      final_q     <= 1'b0;
      w_l_q       <= HW_W'(1);
      held_l_q    <= '0;
    end else if (cmd_i.take) begin
      final_q  <= in_data_i.final_frame;
      w_l_q    <= w_eff;
      held_l_q <= held_q;
      if (last_col) begin
        col_cnt_q <= '0;
        if (in_data_i.final_frame) begin
          frame_cnt_q <= '0;
          slot_q      <= '0;
          held_q      <= '0;
        end else begin
          frame_cnt_q <= frame_cnt_q + FRAME_W'(1);
          slot_q      <= (slot_q == SW'(RING - 1)) ? '0 : slot_q + SW'(1);
          if (held_q < HLW'(RING)) begin
            held_q <= held_q + HLW'(1);
          end
        end
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  // Item payload copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_q   <= in_data_i.sample_value;
      col_l_q   <= col_cnt_q;
      frame_l_q <= frame_cnt_q;
      slot_l_q  <= slot_q;
    end
  end

  // Tap address: frames before the first come from the first-frame row
  logic [HLW-1:0] back;
  logic [RW2-1:0] row_sum;
  logic [SW-1:0]  row;
  logic [AW-1:0]  ring_raddr;
  logic [AW-1:0]  ring_waddr;
  logic           use_first;

  always_comb begin
    if (cmd_i.rd_behind) begin
      back = HLW'(cmd_i.lag) + HLW'(cmd_i.tap);
    end else if (cmd_i.lag >= cmd_i.tap) begin
      back = HLW'(cmd_i.lag - cmd_i.tap);
    end else begin
      back = '0;
    end
    use_first = back > held_l_q;
    row_sum   = RW2'(slot_l_q) + RW2'(RING) - RW2'(back);
    row       = (row_sum >= RW2'(RING)) ? SW'(row_sum - RW2'(RING)) : SW'(row_sum);
    ring_raddr = AW'(row) * AW'(MAX_COLUMNS) + AW'(col_l_q);
    ring_waddr = AW'(slot_l_q) * AW'(MAX_COLUMNS) + AW'(col_l_q);
  end

  // Frame ring and first-frame row
  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] first_rdata;

  drf_ram #(.WIDTH(SAMPLE_W), .DEPTH(RDEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (ring_waddr),
    .wdata_i (value_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  drf_ram #(.WIDTH(SAMPLE_W), .DEPTH(FDEPTH)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && (held_l_q == '0)),
    .waddr_i (FAW'(col_l_q)),
    .wdata_i (value_q),
    .raddr_i (FAW'(col_l_q)),
    .rdata_o (first_rdata)
  );

  // Capture the first-frame value in the cycle after the ring write
  logic                       first_pend_q;
  logic signed [SAMPLE_W-1:0] first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pend_q <= 1'b0;
    end else begin
      first_pend_q <= cmd_i.write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_pend_q) begin
      first_q <= (held_l_q == '0) ? value_q : first_rdata;
    end
  end

  // Tap tag is registered alongside the read data
  logic            tag_vld_q;
  logic            tag_behind_q;
  logic            tag_first_q;
  logic [HW_W-1:0] tag_tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_behind_q <= cmd_i.rd_behind;
    tag_first_q  <= use_first;
    tag_tap_q    <= cmd_i.tap;
  end

  // Weighted accumulate: add l*x ahead, subtract l*x behind
  logic signed [SAMPLE_W-1:0]    tap_data;
  logic signed [HW_W:0]          tap_s;
  logic signed [HW_W+SAMPLE_W:0] prod;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       acc_q;

  assign tap_data = tag_first_q ? first_q : ring_rdata;
  assign tap_s    = {1'b0, tag_tap_q};
  assign prod     = tap_s * tap_data;
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (tag_vld_q) begin
      acc_q <= tag_behind_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end

  // Restoring divider on the magnitude, one quotient bit per cycle
  logic [ACC_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [ACC_W-1:0] quo_signed;

  assign trial      = {rem_q, quo_q[ACC_W-1]};
  assign fits       = trial >= {1'b0, den_q};
  assign quo_signed = neg_q ? -quo_q : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q <= acc_q[ACC_W-1];
      quo_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
      rem_q <= '0;
      den_q <= DENOM_TAB[w_l_q];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], fits};
    end
  end

  // Output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.delta_value   <= quo_signed[DELTA_W-1:0];
      out_data_q.frame_number  <= frame_l_q - FRAME_W'(cmd_i.lag);
      out_data_q.column_number <= COLUMN_W'(col_l_q);
      out_data_q.run_end       <= cmd_i.run_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status for the sequencer
  always_comb begin
    status_o.half_width = w_l_q;
    status_o.final_item = final_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
    if (final_q) begin
      status_o.emit_any  = 1'b1;
      status_o.lag_first = (held_l_q < HLW'(w_l_q)) ? HW_W'(held_l_q) : w_l_q;
    end else begin
      status_o.emit_any  = held_l_q >= HLW'(w_l_q);
      status_o.lag_first = w_l_q;
    end
  end
endmodule

// ----- rtl/core/delta_regression_features.sv -----
// Streaming delta regression over feature frames given value by value in
// row-major order. One item is in work at a time. An item that yields no
// delta is only taken and stored in the frame ring; each delta it yields
// reads the W taps on each side one per cycle from the ring, then runs 42
// steps of the one-bit-per-cycle divider and waits for a free output
// register. Deltas lag W frames; a final-frame value flushes up to W+1
// deltas of its column, oldest first. Configure only while idle.
module delta_regression_features #(
  parameter int unsigned MAX_HALF_WIDTH = 8,
  parameter int unsigned MAX_COLUMNS    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [drf_pkg::CFG_W-1:0] cfg_data_i,
  drf_stream_if.sink                in_i,
  drf_stream_if.source              out_o
);
  import drf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  drf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  drf_datapath #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .MAX_COLUMNS    (MAX_COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // Never overwrite a result still waiting at the output
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a pending result");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |=> !in_i.ready)
    else $error("input accepted while an item is in work");

  // Taps stay within the window
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> (cmd.tap != '0) && (cmd.tap <= status.half_width))
    else $error("tap outside the regression window");
endmodule

// ----- tb/delta_regression_features_tb.sv -----
// Self-checking bench for delta_regression_features: a scoreboard class tracks
// the frame history and predicts every regression delta of the accepted items.
// Depends on drf_pkg, drf_stream_if and the block itself.
`timescale 1ns / 100ps

module delta_regression_features_tb;
  import drf_pkg::*;

  localparam int RING_DEPTH = 17;
  localparam int COL_LIMIT  = 64;
  localparam int STALL_LIMIT = 5000;

  // Frame history and expected deltas
  class delta_tracker;
    int signed   ring_val [RING_DEPTH][COL_LIMIT];
    int signed   first_row [COL_LIMIT];
    int unsigned frame_ctr, col_ctr, slot, held;
    int unsigned half_width_reg, columns_reg;
    out_item_t   pending_deltas [$];
    int unsigned mismatches, deltas_seen;

    function new();
      half_width_reg = 2;
      columns_reg    = 13;
    endfunction

    function void set_reg(cfg_reg_e idx, int unsigned val);
      if (idx == REG_HALF_WIDTH) half_width_reg = val & 4'hF;
      else columns_reg = val & 7'h7F;
    endfunction

    function longint past_val(int unsigned col, int back);
      if (back < 0) back = 0;
      if (back > int'(held)) return first_row[col];
      return ring_val[(slot + RING_DEPTH - back) % RING_DEPTH][col];
    endfunction

    function longint regress_at(int unsigned col, int unsigned w, int unsigned k);
      longint acc;
      longint den;
      acc = 0;
      den = w * (w + 1) * (2 * w + 1) / 3;
      for (int l = 1; l <= int'(w); l++)
        acc += l * (past_val(col, int'(k) - l) - past_val(col, int'(k) + l));
      return acc / den;
    endfunction

    function void push_delta(int unsigned col, int unsigned w, int unsigned k, bit last);
      out_item_t r;
      r.delta_value   = DELTA_W'(regress_at(col, w, k));
      r.frame_number  = FRAME_W'(frame_ctr - k);
      r.column_number = COLUMN_W'(col);
      r.run_end       = last;
      pending_deltas.push_back(r);
    endfunction

    // Note one accepted sample and queue the deltas it releases
    function void take_sample(in_item_t it);
      int unsigned w, cols, col, kmax;
      w = half_width_reg < 1 ? 1 : (half_width_reg > 8 ? 8 : half_width_reg);
      cols = columns_reg < 1 ? 1 : (columns_reg > 64 ? 64 : columns_reg);
      col = col_ctr % COL_LIMIT;
      ring_val[slot][col] = it.sample_value;
      if (held == 0) first_row[col] = it.sample_value;
      if (it.final_frame) begin
        kmax = held < w ? held : w;
        for (int k = int'(kmax); k >= 0; k--) push_delta(col, w, k, k == 0);
      end else if (held >= w) begin
        push_delta(col, w, w, 1'b1);
      end
      if (col_ctr + 1 >= cols) begin
        col_ctr = 0;
        if (it.final_frame) begin
          frame_ctr = 0;
          slot = 0;
          held = 0;
        end else begin
          frame_ctr = (frame_ctr + 1) & 16'hFFFF;
          slot = (slot + 1) % RING_DEPTH;
          if (held < RING_DEPTH) held++;
        end
      end else begin
        col_ctr++;
      end
    endfunction

    // Compare one delta against the oldest expectation
    function void check_delta(out_item_t got);
      out_item_t exp_d;
      deltas_seen++;
      if (pending_deltas.size() == 0) begin
        $error("unexpected delta: frame %0d column %0d", got.frame_number,
               got.column_number);
        mismatches++;
        return;
      end
      exp_d = pending_deltas.pop_front();
      if (got.delta_value !== exp_d.delta_value) begin
        $error("delta_value expected %0d got %0d", exp_d.delta_value, got.delta_value);
        mismatches++;
      end
      if (got.frame_number !== exp_d.frame_number) begin
        $error("frame_number expected %0d got %0d", exp_d.frame_number,
               got.frame_number);
        mismatches++;
      end
      if (got.column_number !== exp_d.column_number) begin
        $error("column_number expected %0d got %0d", exp_d.column_number,
               got.column_number);
        mismatches++;
      end
      if (got.run_end !== exp_d.run_end) begin
        $error("run_end expected %0d got %0d", exp_d.run_end, got.run_end);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  drf_stream_if #(.item_t(in_item_t))  in_ch ();
  drf_stream_if #(.item_t(out_item_t)) out_ch ();

  delta_regression_features dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  delta_tracker tracker = new();
  int unsigned  samples_sent;
  int unsigned  idle_cycles;
  bit           calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random backpressure on the result side
  always @(posedge clk_i) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // Collect results and watch for a hung block
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) tracker.check_delta(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(cfg_reg_e idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  // Present one item, hold it until taken
  task automatic send(logic signed [31:0] val, bit fin);
    in_item_t it;
    it.sample_value = val;
    it.final_frame  = fin;
    calm = samples_sent >= 110 && samples_sent < 180;
    if (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.take_sample(it);
    samples_sent++;
  endtask

  // Wait for every expected delta, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending_deltas.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return 32'($urandom_range(131072)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  // Stream whole frames; the last value carries the final flag, stray ones at random
  task automatic send_sequence(int unsigned frames, int unsigned cols, bit stray);
    for (int f = 0; f < int'(frames); f++)
      for (int c = 0; c < int'(cols); c++)
        send(pick_value(), (f == int'(frames) - 1 && c == int'(cols) - 1) ||
             (stray && $urandom_range(99) < 5));
  endtask

  initial begin
    int unsigned w, cols;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_HALF_WIDTH;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    samples_sent = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of the sample range with the reset window
    cfg_write(REG_COLUMNS, 2);
    send(32'sh7FFF_FFFF, 1'b0); send(32'sh8000_0000, 1'b0);
    send(32'sh8000_0000, 1'b0); send(32'sh7FFF_FFFF, 1'b0);
    send(32'sd0, 1'b0);         send(-32'sd1, 1'b0);
    send(32'sh7FFF_FFFF, 1'b0); send(32'sh8000_0000, 1'b1);
    send(32'sh8000_0000, 1'b1);
    drain();

    // Single-frame sequence, zero registers act as one
    cfg_write(REG_HALF_WIDTH, 0);
    cfg_write(REG_COLUMNS, 0);
    send(32'sh1234_5678, 1'b1);
    drain();

    // Oversized registers clamp; then shrink the frame mid-way
    cfg_write(REG_HALF_WIDTH, 15);
    cfg_write(REG_COLUMNS, 4);
    for (int i = 0; i < 11; i++) send(pick_value(), 1'b0);
    drain();
    cfg_write(REG_COLUMNS, 2);
    send(32'sh0001_0000, 1'b0);
    send(32'shFFFF_0000, 1'b0); send(32'sh0002_0000, 1'b1);
    drain();
    cfg_write(REG_COLUMNS, 127);
    send_sequence(1, 64, 1'b0);
    drain();

    // Random sequences with random window and frame size
    while (samples_sent < 270) begin
      w = $urandom_range(9) == 0 ? ($urandom_range(1) ? 0 : $urandom_range(15, 9))
                                 : $urandom_range(8, 1);
      cols = $urandom_range(5, 1);
      cfg_write(REG_HALF_WIDTH, w);
      cfg_write(REG_COLUMNS, cols);
      send_sequence($urandom_range(14, 1), cols, 1'b1);
      drain();
    end

    $display("Covered %0d samples and %0d deltas over window widths 0..15",
             samples_sent, tracker.deltas_seen);
    $display("and frame sizes 0..127, with stray final flags and a mid-frame shrink.");
    if (tracker.mismatches == 0 && tracker.pending_deltas.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/drf_pkg.sv
rtl/core/drf_stream_if.sv
rtl/core/drf_ram.sv
rtl/core/drf_ctrl.sv
rtl/core/drf_datapath.sv
rtl/core/delta_regression_features.sv
tb/delta_regression_features_tb.sv
